[rtl/mbet_pkg.sv]
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared types and constants of the escape-time pixel engine.
// ----------------------------------------------------------------------------
package mbet_pkg;

  localparam int unsigned PIX_W   = 13;
  localparam int unsigned LIMIT_W = 12;
  localparam int unsigned DIM_W   = 14;
  localparam int unsigned GRAY_W  = 8;
  localparam int unsigned CFG_W   = 14;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 12'd1000;
  localparam logic [DIM_W-1:0]   WIDTH_RST  = 14'd7680;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 14'd4320;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ITER_LIMIT   = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } mbet_cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } mbet_in_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] escape_count;
    logic [GRAY_W-1:0]  gray_level;
  } mbet_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAPX,
    ST_DIVX,
    ST_DIVY,
    ST_MUL,
    ST_UPD,
    ST_GSTART,
    ST_GRAY,
    ST_DONE
  } mbet_state_e;

  // controller -> datapath
  typedef struct packed {
    logic pix_load;
    logic div_start_x;
    logic div_start_y;
    logic div_start_gray;
    logic take_cr;
    logic take_ci;
    logic iter_clear;
    logic mul_en;
    logic upd_en;
    logic take_gray;
    logic gray_zero;
    logic out_load;
  } mbet_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic escape;
    logic last_iter;
    logic lim_zero;
    logic out_free;
  } mbet_status_t;

endpackage

[rtl/mbet_div.sv]
// ----------------------------------------------------------------------------
// mbet_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mbet_div #(
  parameter int unsigned DVW = 39
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [DVW-1:0]                 dividend_i,
  input  logic [mbet_pkg::DIM_W-1:0]     divisor_i,
  output logic                           done_o,
  output logic [DVW-1:0]                 quotient_o,
  output logic                           rem_nz_o
);

  localparam int unsigned DSW    = mbet_pkg::DIM_W;
  localparam int unsigned STEP_W = (DVW > 1) ? $clog2(DVW) : 1;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DVW-1:0]    quo_q, quo_d;
  logic [DSW-1:0]    rem_q, rem_d;
  logic [DSW-1:0]    dvs_q, dvs_d;

  logic [DSW:0]      trial;
  logic              fits;

  always_comb begin
    trial = {rem_q, quo_q[DVW-1]};
    fits  = (trial >= {1'b0, dvs_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DVW-2:0], fits};
      rem_d = fits ? DSW'(trial - {1'b0, dvs_q}) : trial[DSW-1:0];
      if (step_q == STEP_W'(DVW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
  assign rem_nz_o   = |rem_q;

endmodule

[rtl/mbet_datapath.sv]
// ----------------------------------------------------------------------------
// mbet_datapath
// Configuration registers, coordinate mapping, z iteration, gray scaling
// and the output register.
// ----------------------------------------------------------------------------
module mbet_datapath #(
  parameter int unsigned FRAC_BITS  = 24,
  parameter int unsigned COUNT_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mbet_pkg::CFG_W-1:0]        cfg_data_i,
  input  mbet_pkg::mbet_in_t                in_data_i,
  input  mbet_pkg::mbet_cmd_t               cmd_i,
  output mbet_pkg::mbet_status_t            status_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output mbet_pkg::mbet_out_t               out_data_o
);

  localparam int unsigned WW   = 8 + FRAC_BITS;          // fixed-point word
  localparam int unsigned SW   = 2 * WW - FRAC_BITS;     // floored square
  localparam int unsigned DVW  = FRAC_BITS + 15;         // mapping dividend
  localparam int unsigned CNTW = COUNT_BITS;
  localparam int unsigned DIMW = mbet_pkg::DIM_W;
  localparam int unsigned LIMW = mbet_pkg::LIMIT_W;
  localparam int unsigned CNT_MAX = (1 << COUNT_BITS) - 1;

  localparam logic signed [SW:0] FX_FOUR = (SW+1)'(4) <<< FRAC_BITS;

  function automatic logic signed [WW-1:0] sat_word(input logic signed [SW+1:0] v);
    logic [SW+2-WW:0] top;
    top = v[SW+1:WW-1];
    if ((&top) || (~|top)) begin
      return v[WW-1:0];
    end else if (v[SW+1]) begin
      return {1'b1, {(WW-1){1'b0}}};
    end else begin
      return {1'b0, {(WW-1){1'b1}}};
    end
  endfunction

  // ---------------- configuration ----------------
  logic [LIMW-1:0] limit_q;
  logic [DIMW-1:0] width_q;
  logic [DIMW-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= mbet_pkg::LIMIT_RST;
      width_q  <= mbet_pkg::WIDTH_RST;
      height_q <= mbet_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (mbet_pkg::mbet_cfg_idx_e'(cfg_idx_i))
        mbet_pkg::CFG_ITER_LIMIT:   limit_q  <= LIMW'(cfg_data_i);
        mbet_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        mbet_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // limit clamped to what the counter can hold
  logic [15:0]     lim16;
  logic [15:0]     lim16_sat;
  logic [CNTW-1:0] lim_c;
  logic [DIMW-1:0] w_eff;

  always_comb begin
    lim16     = 16'(limit_q);
    lim16_sat = (lim16 > 16'(CNT_MAX)) ? 16'(CNT_MAX) : lim16;
    lim_c     = CNTW'(lim16_sat);
    w_eff     = (width_q == '0) ? DIMW'(1) : width_q;
  end

  // ---------------- pixel and mapping ----------------
  mbet_pkg::mbet_in_t pix_q;

  logic signed [15:0] diff_x, diff_y;
  logic [15:0]        mag_x, mag_y;
  logic [DVW-1:0]     div_dividend;
  logic [DIMW-1:0]    div_divisor;
  logic               div_start;
  logic               div_done;
  logic [DVW-1:0]     div_quo;
  logic               div_rem_nz;
  logic               map_neg_q;

  logic [CNTW-1:0]    cnt_q;
  logic [CNTW+7:0]    gray_num;

  always_comb begin
    diff_x   = $signed({2'b00, pix_q.pixel_x, 1'b0}) - $signed({2'b00, width_q});
    diff_y   = $signed({2'b00, pix_q.pixel_y, 1'b0}) - $signed({2'b00, height_q});
    mag_x    = diff_x[15] ? 16'(-diff_x) : 16'(diff_x);
    mag_y    = diff_y[15] ? 16'(-diff_y) : 16'(diff_y);
    gray_num = ((CNTW+8)'(cnt_q) << 8) - (CNTW+8)'(cnt_q);
    div_start = cmd_i.div_start_x | cmd_i.div_start_y | cmd_i.div_start_gray;
    priority if (cmd_i.div_start_x) begin
      div_dividend = {mag_x[DIMW-1:0], {(FRAC_BITS+1){1'b0}}};
      div_divisor  = w_eff;
    end else if (cmd_i.div_start_y) begin
      div_dividend = {mag_y[DIMW-1:0], {(FRAC_BITS+1){1'b0}}};
      div_divisor  = w_eff;
    end else begin
      div_dividend = DVW'(gray_num);
      div_divisor  = DIMW'(lim_c);
    end
  end

  mbet_div #(
    .DVW (DVW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .rem_nz_o   (div_rem_nz)
  );

  // floor division of a negative numerator: -(q + (rem != 0))
  logic [DVW:0]        q_ext, q_adj;
  logic signed [DVW:0] map_val;
  logic signed [WW-1:0] map_sat;

  always_comb begin
    q_ext   = {1'b0, div_quo};
    q_adj   = q_ext + (DVW+1)'(div_rem_nz);
    map_val = map_neg_q ? $signed(-q_adj) : $signed(q_ext);
    map_sat = sat_word((SW+2)'(map_val));
  end

  // ---------------- iteration ----------------
  logic signed [WW-1:0]   cr_q, ci_q, zr_q, zi_q;
  logic signed [2*WW-1:0] p_rr_q, p_ii_q, p_ri_q;
  logic signed [SW-1:0]   sr, si;
  logic signed [SW:0]     ti, mag2;
  logic signed [SW+1:0]   nr_w, ni_w;
  logic                   escape;
  logic                   last_iter;

  always_comb begin
    sr     = SW'(p_rr_q >>> FRAC_BITS);
    si     = SW'(p_ii_q >>> FRAC_BITS);
    ti     = (SW+1)'(p_ri_q >>> (FRAC_BITS - 1));   // floor(2*zr*zi)
    mag2   = (SW+1)'(sr) + (SW+1)'(si);
    escape = (mag2 > FX_FOUR);
    nr_w   = (SW+2)'(sr) - (SW+2)'(si) + (SW+2)'(cr_q);
    ni_w   = (SW+2)'(ti) + (SW+2)'(ci_q);
    last_iter = ((CNTW+1)'(cnt_q) + (CNTW+1)'(1)) == (CNTW+1)'(lim_c);
  end

  logic [mbet_pkg::GRAY_W-1:0] gray_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_load) begin
      pix_q <= in_data_i;
    end
    if (cmd_i.div_start_x) begin
      map_neg_q <= diff_x[15];
    end else if (cmd_i.div_start_y) begin
      map_neg_q <= diff_y[15];
    end
    if (cmd_i.take_cr) begin
      cr_q <= map_sat;
    end
    if (cmd_i.take_ci) begin
      ci_q <= map_sat;
    end
    if (cmd_i.mul_en) begin
      p_rr_q <= zr_q * zr_q;
      p_ii_q <= zi_q * zi_q;
      p_ri_q <= zr_q * zi_q;
    end
    if (cmd_i.iter_clear) begin
      zr_q  <= '0;
      zi_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.upd_en && !escape) begin
      zr_q  <= sat_word(nr_w);
      zi_q  <= sat_word(ni_w);
      cnt_q <= cnt_q + CNTW'(1);
    end
    if (cmd_i.gray_zero) begin
      gray_q <= '0;
    end else if (cmd_i.take_gray) begin
      gray_q <= mbet_pkg::GRAY_W'(div_quo);
    end
  end

  // ---------------- output register ----------------
  logic                out_valid_q, out_valid_d;
  mbet_pkg::mbet_out_t out_data_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q.escape_count <= LIMW'(cnt_q);
      out_data_q.gray_level   <= gray_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    status_o.div_done  = div_done;
    status_o.escape    = escape;
    status_o.last_iter = last_iter;
    status_o.lim_zero  = (lim_c == '0);
    status_o.out_free  = !out_valid_q || !out_stall_i;
  end

endmodule

[rtl/mbet_ctrl.sv]
// ----------------------------------------------------------------------------
// mbet_ctrl
// Sequencer: mapping divisions, iteration loop, gray division, hand-off.
// ----------------------------------------------------------------------------
module mbet_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  mbet_pkg::mbet_status_t status_i,
  output mbet_pkg::mbet_cmd_t    cmd_o
);

  mbet_pkg::mbet_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbet_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbet_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mbet_pkg::ST_MAPX;
      end
      mbet_pkg::ST_MAPX: state_d = mbet_pkg::ST_DIVX;
      mbet_pkg::ST_DIVX: begin
        if (status_i.div_done) state_d = mbet_pkg::ST_DIVY;
      end
      mbet_pkg::ST_DIVY: begin
        if (status_i.div_done) begin
          state_d = status_i.lim_zero ? mbet_pkg::ST_DONE : mbet_pkg::ST_MUL;
        end
      end
      mbet_pkg::ST_MUL: state_d = mbet_pkg::ST_UPD;
      mbet_pkg::ST_UPD: begin
        if (status_i.escape || status_i.last_iter) state_d = mbet_pkg::ST_GSTART;
        else                                       state_d = mbet_pkg::ST_MUL;
      end
      mbet_pkg::ST_GSTART: state_d = mbet_pkg::ST_GRAY;
      mbet_pkg::ST_GRAY: begin
        if (status_i.div_done) state_d = mbet_pkg::ST_DONE;
      end
      mbet_pkg::ST_DONE: begin
        if (status_i.out_free) state_d = mbet_pkg::ST_IDLE;
      end
      default: state_d = mbet_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      mbet_pkg::ST_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.pix_load = in_valid_i;
      end
      mbet_pkg::ST_MAPX: cmd_o.div_start_x = 1'b1;
      mbet_pkg::ST_DIVX: begin
        cmd_o.take_cr     = status_i.div_done;
        cmd_o.div_start_y = status_i.div_done;
      end
      mbet_pkg::ST_DIVY: begin
        cmd_o.take_ci    = status_i.div_done;
        cmd_o.iter_clear = status_i.div_done;
        cmd_o.gray_zero  = status_i.div_done && status_i.lim_zero;
      end
      mbet_pkg::ST_MUL:    cmd_o.mul_en = 1'b1;
      mbet_pkg::ST_UPD:    cmd_o.upd_en = 1'b1;
      mbet_pkg::ST_GSTART: cmd_o.div_start_gray = 1'b1;
      mbet_pkg::ST_GRAY:   cmd_o.take_gray = status_i.div_done;
      mbet_pkg::ST_DONE:   cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/mandelbrot_escape_time_pixel.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time engine for one pixel per transaction. The pixel is mapped to
// c in signed Q8.FRAC_BITS by two serial divisions, z = z^2 + c is iterated
// with the products registered first and then the add, escape test and
// saturation, and the gray level comes from a third serial division (zero
// when the limit is zero). The three divisions share one radix-2 divider of
// FRAC_BITS+15 steps. One pixel is in flight at a time; a finished result
// waits in an output register while the next pixel is taken. The user must
// write configuration only while no pixel is in flight; the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel #(
  parameter int unsigned FRAC_BITS  = 24,
  parameter int unsigned COUNT_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  mbet_pkg::mbet_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output mbet_pkg::mbet_out_t            out_data_o,
  input  logic                           cfg_we_i,
  input  logic [mbet_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mbet_pkg::CFG_W-1:0]     cfg_data_i
);

  mbet_pkg::mbet_cmd_t    cmd;
  mbet_pkg::mbet_status_t status;

  mbet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mbet_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[dv/tb_mandelbrot_escape_time_pixel.sv]
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time_pixel
// Self-checking bench for the escape-time pixel engine. Pixels are sent
// through the valid/stall input channel. Each accepted transaction gets its
// escape count and gray level from an in-bench fixed-point predictor. Each
// result is checked against the oldest prediction. Both channels idle at
// random. The image size and the iteration limit change between phases,
// and only while the engine is drained.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time_pixel;

  localparam int unsigned FRAC  = 24;
  localparam int unsigned CNT_W = 12;
  localparam longint WORD_HI = (longint'(1) << (FRAC + 7)) - 1;
  localparam longint WORD_LO = -(longint'(1) << (FRAC + 7));
  localparam longint FX_FOUR = longint'(4) << FRAC;

  logic                           clk_i      = 1'b0;
  logic                           rst_ni     = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  mbet_pkg::mbet_in_t             in_data_i  = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  mbet_pkg::mbet_out_t            out_data_o;
  logic                           cfg_we_i   = 1'b0;
  logic [mbet_pkg::CFG_IDX_W-1:0] cfg_idx_i  = mbet_pkg::CFG_ITER_LIMIT;
  logic [mbet_pkg::CFG_W-1:0]     cfg_data_i = '0;

  // bench copy of the engine registers
  logic [mbet_pkg::LIMIT_W-1:0] reg_limit  = mbet_pkg::LIMIT_RST;
  logic [mbet_pkg::DIM_W-1:0]   reg_width  = mbet_pkg::WIDTH_RST;
  logic [mbet_pkg::DIM_W-1:0]   reg_height = mbet_pkg::HEIGHT_RST;

  mbet_pkg::mbet_in_t  pixel_q[$];
  mbet_pkg::mbet_out_t escape_q[$];
  mbet_pkg::mbet_out_t escape_exp;
  int        fail_cnt = 0;
  int        in_hold  = 0;
  int        out_hold = 0;
  bit        idle_en  = 1'b1;

  mandelbrot_escape_time_pixel #(
    .FRAC_BITS  (FRAC),
    .COUNT_BITS (CNT_W)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint clamp_word(longint v);
    if (v > WORD_HI) return WORD_HI;
    if (v < WORD_LO) return WORD_LO;
    return v;
  endfunction

  // full-width product, floored back to FRAC fraction bits
  function automatic longint fx_mul_floor(longint a, longint b);
    logic signed [127:0] pa, pb, wide;
    pa   = a;
    pb   = b;
    wide = (pa * pb) >>> FRAC;
    return wide[63:0];
  endfunction

  // floor((2p - span) * 2^(FRAC+1) / w), saturated
  function automatic longint plane_coord(longint p, longint span, longint w);
    longint num, q;
    num = (2 * p - span) * (longint'(1) << (FRAC + 1));
    q   = num / w;
    if (num < 0 && num % w != 0) q = q - 1;
    return clamp_word(q);
  endfunction

  function automatic mbet_pkg::mbet_out_t escape_time(mbet_pkg::mbet_in_t px);
    longint              cr, ci, zr, zi, sq_r, sq_i, nr, ni, w;
    int unsigned         count, lim;
    mbet_pkg::mbet_out_t res;
    w   = (reg_width == 0) ? 1 : reg_width;
    lim = reg_limit;
    if (lim > (1 << CNT_W) - 1) lim = (1 << CNT_W) - 1;
    cr    = plane_coord(px.pixel_x, reg_width, w);
    ci    = plane_coord(px.pixel_y, reg_height, w);
    zr    = 0;
    zi    = 0;
    count = 0;
    while (count < lim) begin
      sq_r = fx_mul_floor(zr, zr);
      sq_i = fx_mul_floor(zi, zi);
      if (sq_r + sq_i > FX_FOUR) break;
      nr = clamp_word(sq_r - sq_i + cr);
      ni = clamp_word(fx_mul_floor(2 * zr, zi) + ci);
      zr = nr;
      zi = ni;
      count++;
    end
    res.escape_count = count[mbet_pkg::LIMIT_W-1:0];
    res.gray_level   = (lim == 0) ? '0 : mbet_pkg::GRAY_W'((255 * count) / lim);
    return res;
  endfunction

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_hold > 0) begin
        in_hold    <= in_hold - 1;
        in_valid_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        in_hold    <= $urandom_range(0, 3);
        in_valid_i <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pixel_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // predict on every accepted input transaction
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) escape_q.push_back(escape_time(in_data_i));
  end

  // output monitor and stall generator
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (escape_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result: count %0d gray %0d",
                   out_data_o.escape_count, out_data_o.gray_level);
      end else begin
        escape_exp = escape_q.pop_front();
        if (out_data_o.escape_count !== escape_exp.escape_count ||
            out_data_o.gray_level !== escape_exp.gray_level) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: count exp %0d got %0d, gray exp %0d got %0d",
                     escape_exp.escape_count, out_data_o.escape_count,
                     escape_exp.gray_level, out_data_o.gray_level);
        end
      end
    end
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold    <= out_hold - 1;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_hold    <= $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic add_pixel(int unsigned x, int unsigned y);
    mbet_pkg::mbet_in_t px;
    px.pixel_x = x[mbet_pkg::PIX_W-1:0];
    px.pixel_y = y[mbet_pkg::PIX_W-1:0];
    pixel_q.push_back(px);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || in_valid_i || escape_q.size() != 0);
  endtask

  task automatic apply_setup(logic [mbet_pkg::LIMIT_W-1:0] lim,
                             logic [mbet_pkg::DIM_W-1:0] wd,
                             logic [mbet_pkg::DIM_W-1:0] ht);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= mbet_pkg::CFG_ITER_LIMIT;
    cfg_data_i <= mbet_pkg::CFG_W'(lim);
    @(posedge clk_i);
    cfg_idx_i  <= mbet_pkg::CFG_IMAGE_WIDTH;
    cfg_data_i <= wd;
    @(posedge clk_i);
    cfg_idx_i  <= mbet_pkg::CFG_IMAGE_HEIGHT;
    cfg_data_i <= ht;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    reg_limit  = lim;
    reg_width  = wd;
    reg_height = ht;
  endtask

  function automatic logic [mbet_pkg::DIM_W-1:0] rand_dim();
    if ($urandom_range(0, 2) == 0) return mbet_pkg::DIM_W'($urandom_range(1, 64));
    return mbet_pkg::DIM_W'($urandom_range(65, 8192));
  endfunction

  task automatic random_pixels(int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 6) != 0)
        add_pixel($urandom_range(0, reg_width - 1), $urandom_range(0, reg_height - 1));
      else
        add_pixel($urandom_range(0, 8191), $urandom_range(0, 8191));
    end
  endtask

  initial begin
    logic [mbet_pkg::LIMIT_W-1:0] lim;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: center is inside, corners escape quickly
    add_pixel(3840, 2160);
    add_pixel(0, 0);
    add_pixel(8191, 8191);
    add_pixel(0, 8191);
    add_pixel(8191, 0);
    add_pixel(2000, 1500);

    // zero limit, zero width (taken as one), c saturates
    apply_setup(0, 0, 0);
    add_pixel(0, 0);
    add_pixel(8191, 8191);
    add_pixel(1, 1);

    // full limit; c = -2 never escapes, c = +2 escapes on the second step
    apply_setup(4095, 1, 8192);
    add_pixel(0, 4096);
    add_pixel(1, 4096);
    add_pixel(8191, 0);
    add_pixel(0, 0);

    apply_setup(1, 16383, 16383);
    add_pixel(0, 0);
    add_pixel(8191, 8191);
    add_pixel(4096, 100);

    apply_setup(255, 8192, 8192);
    add_pixel(4096, 4096);
    add_pixel(2048, 4096);
    add_pixel(6144, 6144);

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 4) lim = mbet_pkg::LIMIT_W'($urandom_range(1000, 4095));
      else if ($urandom_range(0, 3) == 0) lim = mbet_pkg::LIMIT_W'($urandom_range(65, 400));
      else lim = mbet_pkg::LIMIT_W'($urandom_range(1, 64));
      apply_setup(lim, rand_dim(), rand_dim());
      idle_en = (ph == 9) ? 1'b0 : ($urandom_range(0, 3) != 0);
      random_pixels((ph == 4) ? 8 : 64);
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0 && escape_q.size() == 0) begin
      $display("tb_mandelbrot_escape_time_pixel OK");
    end else begin
      $display("tb_mandelbrot_escape_time_pixel NOT OK");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb_mandelbrot_escape_time_pixel NOT OK");
    $finish;
  end

endmodule
